@@ src/udpr_pkg.sv @@
// Package for the UDP packet reflector: sizes, protocol constants, shared types
// and the reply text table.
// No dependencies.
`default_nettype none

package udpr_pkg;

  // Frame geometry.
  localparam int HDR_BYTES   = 42;
  localparam int REPLY_BYTES = 57;
  localparam int TEXT_BYTES  = 15;
  localparam int HDR_IDX_W   = 6;
  localparam int BANKS       = 2;
  localparam int MEM_DEPTH   = BANKS * HDR_BYTES;
  localparam int MEM_ADDR_W  = $clog2(MEM_DEPTH);

  // Defaults.
  localparam int          FRAME_LIMIT_DEF   = 2048;
  localparam logic [15:0] LISTEN_PORT_RESET = 16'd12345;

  // Protocol fields.
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
  localparam logic [15:0] REPLY_IP_LEN   = 16'd43;
  localparam logic [15:0] REPLY_UDP_LEN  = 16'd23;

  // Configuration port.
  localparam int          MAC_W           = 48;
  localparam int          CFG_IDX_W       = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_PORT = 8'd1;

  // Job queue between the receive and transmit sides.
  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

  // One write into the header buffer.
  typedef struct packed {
    logic                  en;
    logic [MEM_ADDR_W-1:0] addr;
    logic [7:0]            data;
  } hdr_wr_t;

  // One accepted frame waiting for its reply.
  typedef struct packed {
    logic        bank;
    logic [15:0] cksum;
  } job_t;

  // Fixed reply payload, one character per index.
  function automatic logic [7:0] reply_text(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = "P";
      4'd1:    ch = "r";
      4'd2:    ch = "o";
      4'd3:    ch = "c";
      4'd4:    ch = "e";
      4'd5:    ch = "s";
      4'd6:    ch = "s";
      4'd7:    ch = "e";
      4'd8:    ch = "d";
      4'd9:    ch = " ";
      4'd10:   ch = "(";
      4'd11:   ch = "r";
      4'd12:   ch = "a";
      4'd13:   ch = "w";
      4'd14:   ch = ")";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

@@ src/udp_packet_reflector.sv @@
// UDP packet reflector, top level: configuration registers, receive side,
// job queue and transmit side.
// Depends on udpr_pkg, udpr_rx, udpr_jobq and udpr_tx.
//
// Frames arrive one byte per beat on s_axis; the first 42 bytes go into one
// of two header banks. A frame with IPv4 ethertype, UDP protocol, at least
// 42 bytes and destination port equal to listen_port is answered with a
// 57-byte reply on m_axis, one byte per cycle while m_axis_tready is high,
// after the job queue, sequencer, read stage and output register, when tx is
// idle. Input takes one byte per cycle while fewer than two replies are
// pending; with two replies pending (both header banks in use) s_axis_tready
// drops until the older reply has issued its last buffer read. No clearing
// pass is needed after reset. Configuration writes are taken every cycle.
`default_nettype none

module udp_packet_reflector #(
  parameter int FRAME_LIMIT = udpr_pkg::FRAME_LIMIT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,   // in_byte
  input  wire logic                            s_axis_tlast,   // in_last
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [7:0]                           m_axis_tdata,   // out_byte
  output logic                                 m_axis_tlast,   // out_last
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [udpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [udpr_pkg::MAC_W-1:0]      cfg_data
);

  logic [udpr_pkg::MAC_W-1:0]    own_mac;
  logic [15:0]                   listen_port;
  udpr_pkg::hdr_wr_t             hdr_wr;
  logic                          push;
  udpr_pkg::job_t                push_job;
  logic                          pop;
  logic                          head_valid;
  udpr_pkg::job_t                head_job;
  logic [udpr_pkg::JOBQ_CNT_W-1:0] q_count;
  logic                          tx_busy;
  logic [udpr_pkg::JOBQ_CNT_W-1:0] outstanding;

  assign cfg_ready   = 1'b1;
  assign outstanding = q_count + udpr_pkg::JOBQ_CNT_W'(tx_busy);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac     <= '0;
      listen_port <= udpr_pkg::LISTEN_PORT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        udpr_pkg::CFG_OWN_MAC:     own_mac     <= cfg_data;
        udpr_pkg::CFG_LISTEN_PORT: listen_port <= cfg_data[15:0];
        default:                   ;
      endcase
    end
  end

  udpr_rx #(
    .FRAME_LIMIT (FRAME_LIMIT)
  ) u_rx (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .listen_port   (listen_port),
    .outstanding   (outstanding),
    .hdr_wr        (hdr_wr),
    .push          (push),
    .push_job      (push_job)
  );

  udpr_jobq u_jobq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job),
    .count      (q_count)
  );

  udpr_tx u_tx (
    .clk           (clk),
    .rst           (rst),
    .hdr_wr        (hdr_wr),
    .job_valid     (head_valid),
    .job           (head_job),
    .pop           (pop),
    .busy          (tx_busy),
    .own_mac       (own_mac),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ src/udpr_rx.sv @@
// Receive side of the UDP packet reflector: counts frame bytes, writes the
// header into the transmit buffer, checks the frame and queues a reply job.
// Depends on udpr_pkg.
`default_nettype none

module udpr_rx #(
  parameter int FRAME_LIMIT = udpr_pkg::FRAME_LIMIT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [7:0]                        s_axis_tdata,   // in_byte
  input  wire logic                              s_axis_tlast,
  input  wire logic [15:0]                       listen_port,
  input  wire logic [udpr_pkg::JOBQ_CNT_W-1:0]   outstanding,
  output udpr_pkg::hdr_wr_t                      hdr_wr,
  output logic                                   push,
  output udpr_pkg::job_t                         push_job
);

  localparam int CNT_W = $clog2(FRAME_LIMIT + 1);

  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] byte_count_next;
  logic             wr_bank;
  logic [7:0]       ethertype_hi;
  logic [7:0]       ethertype_lo;
  logic [7:0]       ip_proto;
  logic [7:0]       dport_hi;
  logic [7:0]       dport_lo;
  logic [19:0]      ck_acc;
  logic [19:0]      ck_acc_next;
  logic [15:0]      ck_word;
  logic [19:0]      ck_sum;
  logic [16:0]      ck_fold1;
  logic [15:0]      ck_fold2;
  logic             accept;
  logic             in_hdr;
  logic [udpr_pkg::HDR_IDX_W-1:0] idx;
  logic             pass;

  assign s_axis_tready = outstanding < udpr_pkg::JOBQ_CNT_W'(udpr_pkg::JOBQ_DEPTH);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_hdr        = byte_count < CNT_W'(udpr_pkg::HDR_BYTES);
  assign idx           = byte_count[udpr_pkg::HDR_IDX_W-1:0];

  // Saturating byte counter.
  always_comb begin
    if (byte_count < CNT_W'(FRAME_LIMIT)) begin
      byte_count_next = byte_count + CNT_W'(1);
    end else begin
      byte_count_next = byte_count;
    end
  end

  // Header bytes go into the current bank of the transmit buffer.
  always_comb begin
    hdr_wr.en   = accept && in_hdr;
    hdr_wr.data = s_axis_tdata;
    if (wr_bank) begin
      hdr_wr.addr = udpr_pkg::MEM_ADDR_W'(udpr_pkg::HDR_BYTES) + udpr_pkg::MEM_ADDR_W'(idx);
    end else begin
      hdr_wr.addr = udpr_pkg::MEM_ADDR_W'(idx);
    end
  end

  // Bytes of the reply IP header that enter its checksum. Swapped addresses
  // leave the sum unchanged; length and checksum words are constants.
  always_comb begin
    ck_word = 16'h0000;
    if (in_hdr) begin
      case (idx) inside
        [6'd14:6'd15], [6'd18:6'd23], [6'd26:6'd33]: begin
          if (idx[0]) begin
            ck_word = {8'h00, s_axis_tdata};
          end else begin
            ck_word = {s_axis_tdata, 8'h00};
          end
        end
        default: ck_word = 16'h0000;
      endcase
    end
    if (byte_count == '0) begin
      ck_acc_next = 20'(ck_word);
    end else begin
      ck_acc_next = ck_acc + 20'(ck_word);
    end
  end

  // Ones-complement fold of the running sum plus the fixed total length.
  always_comb begin
    ck_sum   = ck_acc + 20'(udpr_pkg::REPLY_IP_LEN);
    ck_fold1 = 17'(ck_sum[15:0]) + 17'(ck_sum[19:16]);
    ck_fold2 = ck_fold1[15:0] + 16'(ck_fold1[16]);
  end

  // Frame check at the last beat.
  always_comb begin
    pass = (byte_count_next >= CNT_W'(udpr_pkg::HDR_BYTES))
        && ({ethertype_hi, ethertype_lo} == udpr_pkg::ETHERTYPE_IPV4)
        && (ip_proto == udpr_pkg::IP_PROTO_UDP)
        && ({dport_hi, dport_lo} == listen_port);
    push           = accept && s_axis_tlast && pass;
    push_job.bank  = wr_bank;
    push_job.cksum = ~ck_fold2;
  end

  // Counter, bank select and the fields the check needs.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      wr_bank    <= 1'b0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        byte_count <= '0;
      end else begin
        byte_count <= byte_count_next;
      end
      if (push) begin
        wr_bank <= ~wr_bank;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ck_acc <= ck_acc_next;
      if (in_hdr) begin
        case (idx)
          6'd12:   ethertype_hi <= s_axis_tdata;
          6'd13:   ethertype_lo <= s_axis_tdata;
          6'd23:   ip_proto     <= s_axis_tdata;
          6'd36:   dport_hi     <= s_axis_tdata;
          6'd37:   dport_lo     <= s_axis_tdata;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ src/udpr_jobq.sv @@
// Two-entry job queue between the receive and transmit sides of the
// UDP packet reflector.
// Depends on udpr_pkg.
`default_nettype none

module udpr_jobq (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  input  udpr_pkg::job_t                       push_job,
  input  wire logic                            pop,
  output logic                                 head_valid,
  output udpr_pkg::job_t                       head_job,
  output logic [udpr_pkg::JOBQ_CNT_W-1:0]      count
);

  localparam int PTR_W = $clog2(udpr_pkg::JOBQ_DEPTH);

  udpr_pkg::job_t   entries [udpr_pkg::JOBQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign head_valid = count != '0;
  assign head_job   = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + udpr_pkg::JOBQ_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - udpr_pkg::JOBQ_CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

`ifndef SYNTHESIS
  jobq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < udpr_pkg::JOBQ_CNT_W'(udpr_pkg::JOBQ_DEPTH)) || pop)
    else $error("job queue written while full");
  jobq_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("job queue read while empty");
`endif

endmodule

`default_nettype wire

@@ src/udpr_tx.sv @@
// Transmit side of the UDP packet reflector: holds the two-bank header buffer
// and streams the 57-byte reply for each queued job.
// Depends on udpr_pkg.
`default_nettype none

module udpr_tx (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  udpr_pkg::hdr_wr_t                hdr_wr,
  input  wire logic                        job_valid,
  input  udpr_pkg::job_t                   job,
  output logic                             pop,
  output logic                             busy,
  input  wire logic [udpr_pkg::MAC_W-1:0]  own_mac,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [7:0]                       m_axis_tdata,   // out_byte
  output logic                             m_axis_tlast
);

  localparam logic [udpr_pkg::HDR_IDX_W-1:0] LAST_IDX =
    udpr_pkg::HDR_IDX_W'(udpr_pkg::REPLY_BYTES - 1);

  logic [7:0]                      hdr_mem [udpr_pkg::MEM_DEPTH];
  logic [udpr_pkg::HDR_IDX_W-1:0]  idx;
  logic                            cur_bank;
  logic [15:0]                     cur_ck;
  logic [udpr_pkg::HDR_IDX_W-1:0]  src_idx;
  logic [udpr_pkg::MEM_ADDR_W-1:0] rd_addr;
  logic [7:0]                      rd_data;
  logic                            a_valid;
  logic [udpr_pkg::HDR_IDX_W-1:0]  a_idx;
  logic [2:0]                      mac_sel;
  logic [udpr_pkg::HDR_IDX_W-1:0]  mac_off;
  logic [7:0]                      reply_byte;
  logic                            o_load;
  logic                            issue;

  assign pop    = !busy && job_valid;
  assign o_load = !m_axis_tvalid || m_axis_tready;
  assign issue  = busy && (!a_valid || o_load);

  // Header byte that feeds each reply byte.
  always_comb begin
    case (idx) inside
      [6'd0:6'd5]:   src_idx = idx + 6'd6;
      [6'd12:6'd41]: src_idx = idx;
      default:       src_idx = '0;
    endcase
    case (idx) inside
      [6'd26:6'd29]: src_idx = idx + 6'd4;
      [6'd30:6'd33]: src_idx = idx - 6'd4;
      [6'd34:6'd35]: src_idx = idx + 6'd2;
      [6'd36:6'd37]: src_idx = idx - 6'd2;
      default:       ;
    endcase
    if (cur_bank) begin
      rd_addr = udpr_pkg::MEM_ADDR_W'(udpr_pkg::HDR_BYTES) + udpr_pkg::MEM_ADDR_W'(src_idx);
    end else begin
      rd_addr = udpr_pkg::MEM_ADDR_W'(src_idx);
    end
  end

  // Header buffer: one write port from the receive side, one registered read.
  always_ff @(posedge clk) begin
    if (hdr_wr.en) begin
      hdr_mem[hdr_wr.addr] <= hdr_wr.data;
    end
    if (issue) begin
      rd_data <= hdr_mem[rd_addr];
    end
  end

  // Reply sequencer: one read issued per beat while the pipeline can move.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      a_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (issue && idx == LAST_IDX) begin
        busy <= 1'b0;
      end
      if (issue) begin
        a_valid <= 1'b1;
      end else if (o_load) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      idx      <= '0;
      cur_bank <= job.bank;
      cur_ck   <= job.cksum;
    end else if (issue) begin
      idx <= idx + 6'd1;
    end
    if (issue) begin
      a_idx <= idx;
    end
  end

  // Reply byte from the read data, the own address, the checksum or a constant.
  always_comb begin
    mac_off = 6'd11 - a_idx;
    mac_sel = mac_off[2:0];
    case (a_idx) inside
      [6'd6:6'd11]:  reply_byte = own_mac[{mac_sel, 3'b000} +: 8];
      6'd16:         reply_byte = udpr_pkg::REPLY_IP_LEN[15:8];
      6'd17:         reply_byte = udpr_pkg::REPLY_IP_LEN[7:0];
      6'd24:         reply_byte = cur_ck[15:8];
      6'd25:         reply_byte = cur_ck[7:0];
      6'd38:         reply_byte = udpr_pkg::REPLY_UDP_LEN[15:8];
      6'd39:         reply_byte = udpr_pkg::REPLY_UDP_LEN[7:0];
      [6'd40:6'd41]: reply_byte = 8'h00;
      [6'd42:6'd56]: reply_byte = udpr_pkg::reply_text(4'(a_idx - 6'd42));
      default:       reply_byte = rd_data;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (o_load) begin
      m_axis_tvalid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load && a_valid) begin
      m_axis_tdata <= reply_byte;
      m_axis_tlast <= a_idx == LAST_IDX;
    end
  end

`ifndef SYNTHESIS
  tx_stage_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && !o_load |=> a_valid && $stable(a_idx))
    else $error("read stage lost its beat under back-pressure");
  tx_done_after_last: assert property (@(posedge clk) disable iff (rst)
    issue && idx == LAST_IDX |=> !busy)
    else $error("sequencer ran past the final reply byte");
  tx_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= LAST_IDX)
    else $error("reply index out of range");
  tx_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> busy && idx == '0)
    else $error("job taken without starting a reply");
`endif

endmodule

`default_nettype wire
